// File: hdl/shp_pkg.sv
// Shared types and constants for the 3x3 cross sharpening stream.
// Used by every module under hdl but shp_ram; has no dependencies of its own.
`default_nettype none
package shp_pkg;

    // Configuration port.
    localparam int CFG_DATA_W  = 12;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

    localparam logic [11:0] RESET_IMAGE_WIDTH   = 12'd640;
    localparam logic [11:0] RESET_IMAGE_HEIGHT  = 12'd480;
    localparam logic [2:0]  RESET_CHANNEL_COUNT = 3'd3;

    // Design limits and parameter defaults.
    localparam int DEF_MAX_WIDTH    = 2048;
    localparam int DEF_MAX_CHANNELS = 4;
    localparam logic [11:0] HEIGHT_LIMIT = 12'd2048;

    // Width used for column arithmetic; holds any width up to 8192 plus one.
    localparam int POS_W = 14;

    // floor(x / 10) for x < 2560 as (x * 52429) >> 19.
    localparam logic [15:0] DIV10_MUL   = 16'd52429;
    localparam int          DIV10_SHIFT = 19;
    localparam logic [11:0] SAT_LIMIT   = 12'd2560;

    // One accepted beat as it leaves the position tracker.
    typedef struct packed {
        logic [7:0]  sample;
        logic        parity;      // row parity, selects the line memory written
        logic        produce;     // this beat completes an interior window
        logic [10:0] row;         // row of the centre pixel
        logic [10:0] col;         // column of the centre pixel
        logic [1:0]  chan;
        logic        last;        // last interior result of the frame
    } beat_t;

endpackage
`default_nettype wire

// File: hdl/shp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Read-first: a read and a write of the same entry in one cycle return the old data.
`default_nettype none
module shp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

endmodule
`default_nettype wire

// File: hdl/shp_ctrl.sv
// Configuration registers and raster position tracking for the sharpening stream.
// Depends on shp_pkg; produces one beat_t per accepted input beat.
`default_nettype none
module shp_ctrl #(
    parameter int MAX_WIDTH    = shp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_CHANNELS = shp_pkg::DEF_MAX_CHANNELS,
    parameter int COL_W        = $clog2(MAX_WIDTH),
    parameter int CH_W         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_we,
    input  wire logic [shp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [shp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic                               s_valid,
    input  wire logic [7:0]                         s_sample,
    input  wire logic                               take,
    output logic                                    accept,
    output shp_pkg::beat_t                          beat,
    output logic [COL_W+CH_W-1:0]                   ram_addr
);

    localparam logic [shp_pkg::POS_W-1:0] MAX_W_POS = shp_pkg::POS_W'(MAX_WIDTH);
    localparam logic [2:0]                MAX_CH3   = 3'(MAX_CHANNELS);

    logic [11:0]      width_reg;
    logic [11:0]      height_reg;
    logic [2:0]       chans_reg;
    logic [10:0]      row_reg;
    logic [COL_W-1:0] col_reg;
    logic [CH_W-1:0]  chan_reg;

    logic [shp_pkg::POS_W-1:0] lim_w;
    logic [11:0]               lim_h;
    logic [2:0]                lim_c;
    logic [shp_pkg::POS_W-1:0] col_pos;
    logic [shp_pkg::POS_W-1:0] col_inc;
    logic [11:0]               row_inc;
    logic [2:0]                chan_inc;
    logic                      col_wrap;
    logic                      row_wrap;
    logic                      chan_wrap;

    always_comb begin
        lim_w = ({2'b00, width_reg} > MAX_W_POS) ? MAX_W_POS : {2'b00, width_reg};
        lim_h = (height_reg > shp_pkg::HEIGHT_LIMIT) ? shp_pkg::HEIGHT_LIMIT : height_reg;
        if (chans_reg == 3'd0) begin
            lim_c = 3'd1;
        end else begin
            lim_c = (chans_reg > MAX_CH3) ? MAX_CH3 : chans_reg;
        end

        col_pos   = shp_pkg::POS_W'(col_reg);
        col_inc   = col_pos + shp_pkg::POS_W'(1);
        row_inc   = {1'b0, row_reg} + 12'd1;
        chan_inc  = 3'(chan_reg) + 3'd1;
        col_wrap  = col_inc >= lim_w;
        row_wrap  = row_inc >= lim_h;
        chan_wrap = chan_inc >= lim_c;

        accept = s_valid && take;

        beat.sample  = s_sample;
        beat.parity  = row_reg[0];
        // The window around pixel (r-1, c-1) is complete when (r, c) arrives.
        beat.produce = (row_reg >= 11'd2) && (col_pos >= shp_pkg::POS_W'(2))
                    && (row_inc <= lim_h) && (col_inc <= lim_w);
        beat.row     = row_reg - 11'd1;
        beat.col     = 11'(col_pos - shp_pkg::POS_W'(1));
        beat.chan    = 2'(chan_reg);
        beat.last    = (row_inc == lim_h) && (col_inc == lim_w) && (chan_inc == lim_c);

        ram_addr = {col_reg, chan_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= shp_pkg::RESET_IMAGE_WIDTH;
            height_reg <= shp_pkg::RESET_IMAGE_HEIGHT;
            chans_reg  <= shp_pkg::RESET_CHANNEL_COUNT;
            row_reg    <= '0;
            col_reg    <= '0;
            chan_reg   <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                shp_pkg::REG_IMAGE_WIDTH:   width_reg  <= cfg_wdata;
                shp_pkg::REG_IMAGE_HEIGHT:  height_reg <= cfg_wdata;
                shp_pkg::REG_CHANNEL_COUNT: chans_reg  <= cfg_wdata[2:0];
                default: ;
            endcase
            // Any write, known index or not, restarts the frame position.
            row_reg  <= '0;
            col_reg  <= '0;
            chan_reg <= '0;
        end else if (accept) begin
            if (chan_wrap) begin
                chan_reg <= '0;
                if (col_wrap) begin
                    col_reg <= '0;
                    row_reg <= row_wrap ? 11'd0 : row_inc[10:0];
                end else begin
                    col_reg <= col_inc[COL_W-1:0];
                end
            end else begin
                chan_reg <= chan_inc[CH_W-1:0];
            end
        end
    end

endmodule
`default_nettype wire

// File: hdl/shp_kernel.sv
// Window registers and the three-stage cross-kernel datapath with its output register.
// Depends on shp_pkg; takes beats from shp_ctrl and line data from two shp_ram instances.
`default_nettype none
module shp_kernel #(
    parameter int CH_W = 2
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           beat_valid,
    input  wire shp_pkg::beat_t beat,
    output logic                in_ready,
    input  wire logic [7:0]     line0_data,
    input  wire logic [7:0]     line1_data,
    input  wire logic           m_ready,
    output logic                m_valid,
    output logic [7:0]          m_sharpened,
    output logic [10:0]         m_out_row,
    output logic [10:0]         m_out_column,
    output logic [1:0]          m_out_channel,
    output logic                m_frame_done
);

    localparam int WIN = 2 ** CH_W;

    // Stage 1: beat registered alongside the line memory read data.
    logic           v1_reg;
    shp_pkg::beat_t b1_reg;

    // Per-channel window registers.
    logic [7:0] north_reg  [WIN];
    logic [7:0] centre_reg [WIN];
    logic [7:0] west_reg   [WIN];
    logic [7:0] south_reg  [WIN];

    // Stage 2: kernel sum split into sign, saturation and magnitude.
    logic        v2_reg;
    logic        neg2_reg;
    logic        sat2_reg;
    logic [11:0] mag2_reg;
    logic [10:0] row2_reg;
    logic [10:0] col2_reg;
    logic [1:0]  chan2_reg;
    logic        last2_reg;

    logic            m_valid_reg;
    logic [7:0]      sharp_reg;
    logic [10:0]     row3_reg;
    logic [10:0]     col3_reg;
    logic [1:0]      chan3_reg;
    logic            last3_reg;

    logic            ready2;
    logic            ready3;
    logic            adv1;
    logic [CH_W-1:0] ch;
    logic [7:0]      above2;
    logic [7:0]      east;
    logic [11:0]     centre14;
    logic [9:0]      ring_sum;
    logic [12:0]     v_next;
    logic [27:0]     prod;
    logic [7:0]      sharp_next;

    always_comb begin
        ready3   = !m_valid_reg || m_ready;
        ready2   = !v2_reg || ready3;
        in_ready = !v1_reg || ready2;
        adv1     = v1_reg && ready2;

        ch = b1_reg.chan[CH_W-1:0];
        // The memory of this row's parity holds row r-2; the other holds row r-1.
        above2 = b1_reg.parity ? line1_data : line0_data;
        east   = b1_reg.parity ? line0_data : line1_data;

        centre14 = {centre_reg[ch], 4'b0000} - {3'b000, centre_reg[ch], 1'b0};
        ring_sum = 10'(north_reg[ch]) + 10'(south_reg[ch]) + 10'(west_reg[ch]) + 10'(east);
        v_next   = {1'b0, centre14} - {3'b000, ring_sum};

        prod = 28'(mag2_reg) * 28'(shp_pkg::DIV10_MUL);
        if (neg2_reg) begin
            sharp_next = 8'd0;
        end else if (sat2_reg) begin
            sharp_next = 8'd255;
        end else begin
            sharp_next = 8'(prod >> shp_pkg::DIV10_SHIFT);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                v1_reg <= beat_valid;
            end
            if (ready2) begin
                v2_reg <= adv1 && b1_reg.produce;
            end
            if (ready3) begin
                m_valid_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            b1_reg <= beat;
        end
        if (adv1) begin
            north_reg[ch]  <= above2;
            west_reg[ch]   <= centre_reg[ch];
            centre_reg[ch] <= east;
            south_reg[ch]  <= b1_reg.sample;
        end
        if (ready2) begin
            neg2_reg  <= v_next[12] || (v_next == 13'd0);
            sat2_reg  <= !v_next[12] && (v_next[11:0] >= shp_pkg::SAT_LIMIT);
            mag2_reg  <= v_next[11:0];
            row2_reg  <= b1_reg.row;
            col2_reg  <= b1_reg.col;
            chan2_reg <= b1_reg.chan;
            last2_reg <= b1_reg.last;
        end
        if (ready3) begin
            sharp_reg <= sharp_next;
            row3_reg  <= row2_reg;
            col3_reg  <= col2_reg;
            chan3_reg <= chan2_reg;
            last3_reg <= last2_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_sharpened   = sharp_reg;
    assign m_out_row     = row3_reg;
    assign m_out_column  = col3_reg;
    assign m_out_channel = chan3_reg;
    assign m_frame_done  = last3_reg;

endmodule
`default_nettype wire

// File: hdl/sharpen_3x3_cross_stream.sv
// 3x3 cross sharpening of an interleaved raster stream, one sample beat per cycle.
// Each result is registered in stage 1, stage 2 and the output register.
// Throughput: one beat per cycle unless stalled; each beat reads both line memories, writes one.
// Results stall only while the output register holds a beat that is not taken.
// Reset loads the default size and channel count and restarts at row 0, column 0.
// The line memories are not cleared; the first two rows of a frame give no result.
`default_nettype none
module sharpen_3x3_cross_stream #(
    parameter int MAX_WIDTH    = shp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_CHANNELS = shp_pkg::DEF_MAX_CHANNELS
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [shp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [shp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [7:0]                       s_sample,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [7:0]                            m_sharpened,
    output logic [10:0]                           m_out_row,
    output logic [10:0]                           m_out_column,
    output logic [1:0]                            m_out_channel,
    output logic                                  m_frame_done
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int ADDR_W = COL_W + CH_W;
    localparam int LINE_DEPTH = 2 ** ADDR_W;

    logic              accept;
    logic              take;
    shp_pkg::beat_t    beat;
    logic [ADDR_W-1:0] ram_addr;
    logic [7:0]        line0_data;
    logic [7:0]        line1_data;

    assign s_ready = take;

    shp_ctrl #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS),
        .COL_W        (COL_W),
        .CH_W         (CH_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_sample  (s_sample),
        .take      (take),
        .accept    (accept),
        .beat      (beat),
        .ram_addr  (ram_addr)
    );

    // One memory per row parity. Both are read at the current column and channel;
    // the sample is written over the entry of row r-2 in the same cycle.
    shp_ram #(
        .WIDTH (8),
        .DEPTH (LINE_DEPTH)
    ) u_line0 (
        .aclk  (aclk),
        .we    (accept && !beat.parity),
        .waddr (ram_addr),
        .wdata (s_sample),
        .re    (accept),
        .raddr (ram_addr),
        .rdata (line0_data)
    );

    shp_ram #(
        .WIDTH (8),
        .DEPTH (LINE_DEPTH)
    ) u_line1 (
        .aclk  (aclk),
        .we    (accept && beat.parity),
        .waddr (ram_addr),
        .wdata (s_sample),
        .re    (accept),
        .raddr (ram_addr),
        .rdata (line1_data)
    );

    shp_kernel #(
        .CH_W (CH_W)
    ) u_kernel (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .beat_valid    (accept),
        .beat          (beat),
        .in_ready      (take),
        .line0_data    (line0_data),
        .line1_data    (line1_data),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_sharpened   (m_sharpened),
        .m_out_row     (m_out_row),
        .m_out_column  (m_out_column),
        .m_out_channel (m_out_channel),
        .m_frame_done  (m_frame_done)
    );

endmodule
`default_nettype wire

// File: test/tb.sv
// Self-checking testbench for sharpen_3x3_cross_stream: random sample beats are pushed
// through the block and each result is checked against a predictor of the cross kernel.
// Depends on shp_pkg and the top module under hdl; reads no files.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MEM_COLS = shp_pkg::DEF_MAX_WIDTH;
    localparam int MEM_CHANS = shp_pkg::DEF_MAX_CHANNELS;
    localparam int HEIGHT_CAP = 2048;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES = 16;
    localparam int TAIL_BEATS = 300;
    localparam int RANDOM_BEATS = 1630;
    localparam int PRINT_CAP = 30;
    localparam logic [shp_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum logic [1:0] {CMD_SAMPLE, CMD_WRITE, CMD_HOLD} stream_kind_t;
    typedef enum int {PIX_UNIFORM, PIX_EXTREME, PIX_SMOOTH, PIX_SPIKY} pixel_style_t;

    typedef struct packed {
        stream_kind_t                    kind;
        logic [shp_pkg::CFG_INDEX_W-1:0] index;
        logic [shp_pkg::CFG_DATA_W-1:0]  data;
        logic [7:0]                      sample;
    } stream_cmd_t;

    typedef struct packed {
        logic [7:0]  value;
        logic [10:0] row;
        logic [10:0] column;
        logic [1:0]  channel;
        logic        frame_done;
    } sharpened_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [shp_pkg::CFG_INDEX_W-1:0] cfg_index = shp_pkg::REG_IMAGE_WIDTH;
    logic [shp_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                            s_valid = 1'b0;
    wire                             s_ready;
    logic [7:0]                      s_sample = 8'd0;
    wire                             m_valid;
    logic                            m_ready = 1'b0;
    wire [7:0]                       m_sharpened;
    wire [10:0]                      m_out_row;
    wire [10:0]                      m_out_column;
    wire [1:0]                       m_out_channel;
    wire                             m_frame_done;

    sharpen_3x3_cross_stream dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample      (s_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sharpened   (m_sharpened),
        .m_out_row     (m_out_row),
        .m_out_column  (m_out_column),
        .m_out_channel (m_out_channel),
        .m_frame_done  (m_frame_done)
    );

    stream_cmd_t stream_cmds_q[$];
    sharpened_t  sharpened_q[$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          cycle_limit = 1000000;
    int          idle_left = 0;
    int          stall_left = 0;
    int          quiet_cycles = 0;
    logic        gaps_on = 1'b1;
    logic        stalls_on = 1'b1;
    logic        calm_tail = 1'b0;

    // Predictor state: configuration, the two stored rows and the per-channel windows.
    logic [11:0]  cfg_width_q = shp_pkg::RESET_IMAGE_WIDTH;
    logic [11:0]  cfg_height_q = shp_pkg::RESET_IMAGE_HEIGHT;
    logic [2:0]   cfg_chans_q = shp_pkg::RESET_CHANNEL_COUNT;
    logic [7:0]   line_mem [2*MEM_COLS*MEM_CHANS];
    logic [7:0]   north_win [MEM_CHANS];
    logic [7:0]   centre_win [MEM_CHANS];
    logic [7:0]   west_win [MEM_CHANS];
    logic [7:0]   south_win [MEM_CHANS];
    int unsigned  row_pos = 0;
    int unsigned  col_pos = 0;
    int unsigned  chan_pos = 0;

    // Three 3x3 frames: a bright centre that saturates high, a dark centre that
    // clamps to zero, and a mixed one whose quotient has to be floored.
    logic [7:0] probe_frames [27] = '{
        8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd0,   8'd0,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   8'd255, 8'd255, 8'd255, 8'd255,
        8'd7,   8'd13,  8'd200, 8'd1,   8'd51,  8'd3,   8'd90,  8'd2,   8'd254
    };

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    function automatic void apply_register_write(
            input logic [shp_pkg::CFG_INDEX_W-1:0] idx,
            input logic [shp_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            shp_pkg::REG_IMAGE_WIDTH: cfg_width_q = data;
            shp_pkg::REG_IMAGE_HEIGHT: cfg_height_q = data;
            shp_pkg::REG_CHANNEL_COUNT: cfg_chans_q = data[2:0];
            default: ;
        endcase
        // Every write, even to an unused index, restarts the raster position.
        row_pos = 0;
        col_pos = 0;
        chan_pos = 0;
    endfunction

    function automatic void sharpen_predict(input logic [7:0] smp);
        int unsigned w, h, nch, col, ch, older, newer;
        int          v;
        logic [7:0]  above2, east;
        sharpened_t  want;
        w = (cfg_width_q > MEM_COLS) ? MEM_COLS : cfg_width_q;
        h = (cfg_height_q > HEIGHT_CAP) ? HEIGHT_CAP : cfg_height_q;
        if (cfg_chans_q == 0)
            nch = 1;
        else
            nch = (cfg_chans_q > MEM_CHANS) ? MEM_CHANS : cfg_chans_q;
        col = (col_pos < MEM_COLS) ? col_pos : MEM_COLS - 1;
        ch = (chan_pos < MEM_CHANS) ? chan_pos : MEM_CHANS - 1;
        older = ((row_pos % 2) * MEM_COLS + col) * MEM_CHANS + ch;
        newer = (((row_pos + 1) % 2) * MEM_COLS + col) * MEM_CHANS + ch;
        above2 = line_mem[older];
        east = line_mem[newer];

        // The beat at (r, c) completes the window centred on (r-1, c-1).
        if (row_pos >= 2 && col_pos >= 2 && row_pos + 1 <= h && col_pos + 1 <= w) begin
            v = 14 * int'(centre_win[ch]) - int'(north_win[ch]) - int'(south_win[ch])
                - int'(west_win[ch]) - int'(east);
            if (v <= 0)
                want.value = 8'd0;
            else if (v / 10 > 255)
                want.value = 8'd255;
            else
                want.value = 8'(v / 10);
            want.row = 11'(row_pos - 1);
            want.column = 11'(col_pos - 1);
            want.channel = 2'(chan_pos);
            want.frame_done = (row_pos + 1 == h && col_pos + 1 == w && chan_pos + 1 == nch);
            sharpened_q.push_back(want);
        end

        north_win[ch] = above2;
        west_win[ch] = centre_win[ch];
        centre_win[ch] = east;
        south_win[ch] = smp;
        line_mem[older] = smp;

        chan_pos++;
        if (chan_pos >= nch) begin
            chan_pos = 0;
            col_pos++;
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= h)
                    row_pos = 0;
            end
        end
    endfunction

    function automatic logic [7:0] pick_sample(input pixel_style_t style);
        case (style)
            PIX_EXTREME: return ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255;
            PIX_SMOOTH: return 8'($urandom_range(96, 160));
            PIX_SPIKY: return ($urandom_range(0, 7) == 0) ? 8'd255 : 8'($urandom_range(0, 20));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic queue_sample(input logic [7:0] v);
        stream_cmd_t cmd;
        cmd.kind = CMD_SAMPLE;
        cmd.index = shp_pkg::REG_IMAGE_WIDTH;
        cmd.data = '0;
        cmd.sample = v;
        stream_cmds_q.push_back(cmd);
    endtask

    task automatic queue_samples(input int count, input pixel_style_t style);
        for (int i = 0; i < count; i++)
            queue_sample(pick_sample(style));
    endtask

    task automatic queue_write(input logic [shp_pkg::CFG_INDEX_W-1:0] idx,
                               input logic [shp_pkg::CFG_DATA_W-1:0] data);
        stream_cmd_t cmd;
        cmd.kind = CMD_WRITE;
        cmd.index = idx;
        cmd.data = data;
        cmd.sample = 8'd0;
        stream_cmds_q.push_back(cmd);
    endtask

    task automatic queue_hold();
        stream_cmd_t cmd;
        cmd.kind = CMD_HOLD;
        cmd.index = shp_pkg::REG_IMAGE_WIDTH;
        cmd.data = '0;
        cmd.sample = 8'd0;
        stream_cmds_q.push_back(cmd);
    endtask

    task automatic queue_shape(input int w, input int h, input int nch);
        queue_write(shp_pkg::REG_IMAGE_WIDTH, 12'(w));
        queue_write(shp_pkg::REG_IMAGE_HEIGHT, 12'(h));
        queue_write(shp_pkg::REG_CHANNEL_COUNT, {9'($urandom_range(0, 511)), 3'(nch)});
    endtask

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin : run_test
        int random_beats;
        int w, h, nch, eff_chans, beats, half;
        pixel_style_t style;

        foreach (line_mem[i])
            line_mem[i] = 8'd0;
        foreach (north_win[i]) begin
            north_win[i] = 8'd0;
            centre_win[i] = 8'd0;
            west_win[i] = 8'd0;
            south_win[i] = 8'd0;
        end

        // Reset sizes: a short run into the first row, which gives no result yet.
        queue_samples(30, PIX_UNIFORM);
        queue_hold();

        queue_shape(3, 3, 1);
        foreach (probe_frames[i])
            queue_sample(probe_frames[i]);

        // Channel count at its maximum, at zero and above the maximum.
        queue_shape(4, 3, 4);
        queue_samples(4 * 3 * 4, PIX_EXTREME);
        queue_shape(5, 3, 0);
        queue_samples(5 * 3, PIX_UNIFORM);
        queue_shape(3, 4, 7);
        queue_samples(3 * 4 * 4, PIX_SPIKY);

        // Frames too small to hold an interior pixel.
        queue_shape(2, 4, 1);
        queue_samples(10, PIX_UNIFORM);
        queue_shape(5, 2, 2);
        queue_samples(22, PIX_UNIFORM);
        queue_shape(0, 0, 1);
        queue_samples(6, PIX_UNIFORM);

        // A write to the unused index in the middle of a frame restarts the position.
        queue_shape(6, 5, 1);
        queue_samples(14, PIX_UNIFORM);
        queue_hold();
        queue_write(REG_UNUSED, 12'($urandom_range(0, 4095)));
        queue_samples(6 * 5 + 3, PIX_SMOOTH);

        // Width and height beyond the store limit act as the limit.
        queue_shape(4095, 3, 1);
        queue_samples(40, PIX_UNIFORM);
        queue_shape(3, 4095, 1);
        queue_samples(3 * 8, PIX_UNIFORM);

        random_beats = 0;
        while (random_beats < RANDOM_BEATS) begin
            case ($urandom_range(0, 9))
                0: w = $urandom_range(0, 2);
                1, 2: w = $urandom_range(11, 40);
                default: w = $urandom_range(3, 10);
            endcase
            h = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
            nch = $urandom_range(0, 7);
            eff_chans = (nch == 0) ? 1 : ((nch > MEM_CHANS) ? MEM_CHANS : nch);
            if ($urandom_range(0, 5) == 0)
                queue_write(REG_UNUSED, 12'($urandom_range(0, 4095)));
            queue_shape(w, h, nch);
            beats = w * h * eff_chans * $urandom_range(1, 2);
            if (beats == 0)
                beats = $urandom_range(4, 12);
            else if ($urandom_range(0, 3) == 0)
                beats = $urandom_range(1, beats);
            if (beats > RANDOM_BEATS - random_beats)
                beats = RANDOM_BEATS - random_beats;
            style = pixel_style_t'($urandom_range(0, 3));
            if ($urandom_range(0, 3) == 0) begin
                half = beats / 2;
                queue_samples(half, style);
                queue_hold();
                queue_samples(beats - half, style);
            end else begin
                queue_samples(beats, style);
            end
            random_beats += beats;
        end

        cycle_limit = 40 * stream_cmds_q.size() + 20000;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        do
            @(negedge aclk);
        while (stream_cmds_q.size() != 0 || s_valid || sharpened_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    always @(posedge aclk) begin : drive_stream
        stream_cmd_t head;
        logic        present;
        logic        write_now;
        logic [7:0]  next_sample;
        logic        settled;
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_sample <= 8'd0;
            cfg_we <= 1'b0;
            idle_left = 0;
            quiet_cycles = 0;
        end else begin
            present = 1'b0;
            write_now = 1'b0;
            next_sample = s_sample;
            if (s_valid && s_ready) begin
                sharpen_predict(s_sample);
                quiet_cycles = 0;
            end else if (quiet_cycles < SETTLE_CYCLES) begin
                quiet_cycles++;
            end
            // A beat that produces no result may still be in flight, so writes
            // also wait until the stream has settled after the last accepted beat.
            settled = (sharpened_q.size() == 0 && quiet_cycles >= SETTLE_CYCLES);

            if (s_valid && !s_ready) begin
                present = 1'b1;
            end else if (idle_left > 0) begin
                idle_left--;
            end else if (stream_cmds_q.size() != 0) begin
                head = stream_cmds_q[0];
                case (head.kind)
                    CMD_SAMPLE: begin
                        if (gaps_on && stream_cmds_q.size() > TAIL_BEATS
                                && $urandom_range(0, 5) == 0) begin
                            idle_left = $urandom_range(0, 3);
                        end else begin
                            present = 1'b1;
                            next_sample = head.sample;
                            void'(stream_cmds_q.pop_front());
                            if ($urandom_range(0, 99) == 0)
                                gaps_on = !gaps_on;
                        end
                    end
                    CMD_WRITE: begin
                        if (settled) begin
                            write_now = 1'b1;
                            cfg_index <= head.index;
                            cfg_wdata <= head.data;
                            apply_register_write(head.index, head.data);
                            void'(stream_cmds_q.pop_front());
                        end
                    end
                    default: begin
                        if (settled)
                            void'(stream_cmds_q.pop_front());
                    end
                endcase
            end
            s_valid <= present;
            s_sample <= next_sample;
            cfg_we <= write_now;
            calm_tail <= (stream_cmds_q.size() <= TAIL_BEATS);
        end
    end

    always @(posedge aclk) begin : watch_results
        sharpened_t got;
        sharpened_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                got = '{m_sharpened, m_out_row, m_out_column, m_out_channel, m_frame_done};
                if (sharpened_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat: %0d r%0d c%0d ch%0d done %0b",
                        got.value, got.row, got.column, got.channel, got.frame_done));
                end else begin
                    want = sharpened_q.pop_front();
                    if (got !== want)
                        report_mismatch($sformatf(
                            "got %0d r%0d c%0d ch%0d done %0b, want %0d r%0d c%0d ch%0d done %0b",
                            got.value, got.row, got.column, got.channel, got.frame_done,
                            want.value, want.row, want.column, want.channel, want.frame_done));
                end
            end

            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (stalls_on && !calm_tail && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 3);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 149) == 0)
                    stalls_on = !stalls_on;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > cycle_limit) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule
